### rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = 7;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    localparam logic [2:0] REQ_READ     = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD = 3'd1;
    localparam logic [2:0] REQ_INS_TAIL = 3'd2;
    localparam logic [2:0] REQ_INS_AT   = 3'd3;
    localparam logic [2:0] REQ_DELETE   = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [LEN_W-1:0]   position;
        logic signed [31:0] value;
    } ilid_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic               applied;
        logic               full_res;
        logic [LEN_W-1:0]   length_now;
    } ilid_out_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_READ,
        K_INSERT,
        K_DELETE
    } ilid_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SHIFT,
        ST_PUT,
        ST_DROP,
        ST_DONE
    } ilid_state_t;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic wr_shift;
        logic put;
        logic drop;
        logic finish;
    } ilid_cmd_t;

    typedef struct packed {
        ilid_kind_t kind;
        logic       more;
        logic       out_free;
    } ilid_status_t;

endpackage

`default_nettype wire

### rtl/ilid_datapath.sv
// ----------------------------------------------------------------------------
// ilid_datapath
// Entry memory, length count, shift cursor and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_datapath import ilid_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ilid_in_t     in_data,
    input  wire ilid_cmd_t    cmd,
    input  wire logic         out_stall,
    output ilid_status_t      status,
    output logic              out_valid,
    output ilid_out_t         out_data
);

    logic signed [31:0] mem [CAPACITY];

    ilid_kind_t         kind_reg,   kind_next;
    logic               full_reg,   full_next;
    logic [LEN_W-1:0]   ipos_reg,   ipos_next;
    logic [LEN_W-1:0]   cursor_reg, cursor_next;
    logic [LEN_W-1:0]   length_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] rdata_reg;
    logic               out_valid_reg;
    ilid_out_t          out_data_reg;

    logic [LEN_W-1:0]   raddr;
    logic               ins;
    logic [LEN_W-1:0]   ins_pos;

    // request decode against the current length
    always_comb
    begin
        kind_next   = K_NONE;
        full_next   = 1'b0;
        ipos_next   = in_data.position;
        cursor_next = in_data.position;
        ins         = 1'b0;
        ins_pos     = '0;
        unique case (in_data.req_type)
            REQ_READ:
            begin
                if (in_data.position < length_reg)
                begin
                    kind_next = K_READ;
                end
            end
            REQ_INS_HEAD:
            begin
                ins     = 1'b1;
                ins_pos = '0;
            end
            REQ_INS_TAIL:
            begin
                ins     = 1'b1;
                ins_pos = length_reg;
            end
            REQ_INS_AT:
            begin
                if (in_data.position <= length_reg)
                begin
                    ins     = 1'b1;
                    ins_pos = in_data.position;
                end
            end
            REQ_DELETE:
            begin
                if (in_data.position < length_reg)
                begin
                    kind_next = K_DELETE;
                end
            end
            default:
            begin
            end
        endcase
        if (ins)
        begin
            ipos_next = ins_pos;
            if (length_reg >= CAP_LEN)
            begin
                full_next = 1'b1;
            end
            else
            begin
                kind_next   = K_INSERT;
                cursor_next = length_reg;
            end
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            K_INSERT: raddr = cursor_reg - LEN_W'(1);
            K_DELETE: raddr = cursor_reg + LEN_W'(1);
            default:  raddr = ipos_reg;
        endcase
    end

    always_comb
    begin
        status.kind     = kind_reg;
        status.out_free = !out_valid_reg || !out_stall;
        unique case (kind_reg)
            K_INSERT: status.more = cursor_reg > ipos_reg;
            K_DELETE: status.more = ({1'b0, cursor_reg} + (LEN_W+1)'(1))
                                    < {1'b0, length_reg};
            default:  status.more = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= K_NONE;
            full_reg      <= 1'b0;
            cursor_reg    <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg   <= kind_next;
                full_reg   <= full_next;
                cursor_reg <= cursor_next;
            end
            else if (cmd.wr_shift)
            begin
                cursor_reg <= (kind_reg == K_INSERT) ? cursor_reg - LEN_W'(1)
                                                     : cursor_reg + LEN_W'(1);
            end
            if (cmd.put)
            begin
                length_reg <= length_reg + LEN_W'(1);
            end
            else if (cmd.drop)
            begin
                length_reg <= length_reg - LEN_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ipos_reg  <= ipos_next;
            value_reg <= in_data.value;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[raddr[IDX_W-1:0]];
        end
        if (cmd.finish)
        begin
            out_data_reg.read_value <= (kind_reg == K_READ) ? rdata_reg : '0;
            out_data_reg.found      <= kind_reg == K_READ;
            out_data_reg.applied    <= (kind_reg == K_INSERT) || (kind_reg == K_DELETE);
            out_data_reg.full_res   <= full_reg;
            out_data_reg.length_now <= length_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift)
        begin
            mem[cursor_reg[IDX_W-1:0]] <= rdata_reg;
        end
        else if (cmd.put)
        begin
            mem[ipos_reg[IDX_W-1:0]] <= value_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/ilid_controller.sv
// ----------------------------------------------------------------------------
// ilid_controller
// Request sequencer: decode, shift loop, length update, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_controller import ilid_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire ilid_status_t status,
    output ilid_cmd_t         cmd
);

    ilid_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (status.kind)
                    K_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_DONE;
                    end
                    K_INSERT:
                    begin
                        if (status.more)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_SHIFT;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    K_DELETE:
                    begin
                        if (status.more)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_SHIFT;
                        end
                        else
                        begin
                            state_next = ST_DROP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/indexed_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of up to CAPACITY signed words with read, insert and delete.
// ----------------------------------------------------------------------------
// Channel   Signals                     Direction
// in        in_valid, in_stall, in_data  request item in, stall out
// out       out_valid, out_stall, out_data  result item out, stall in
//
// One item at a time. A read, miss, refused or unknown request goes from decode
// straight to the result register. An insert or delete that changes the list
// first moves the entries behind its position, reading and then writing one
// entry per step, then writes the new value or shortens the list.
// The result register frees the sequencer while a result waits on out_stall.
// Reset clears length and control; entry contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete_unit import ilid_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire ilid_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output ilid_out_t     out_data
);

    ilid_cmd_t    cmd;
    ilid_status_t status;

    ilid_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ilid_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/ilid_checker.sv
// ----------------------------------------------------------------------------
// ilid_checker
// Port-level checks for the indexed list unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_checker import ilid_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire ilid_in_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire ilid_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.length_now <= CAP_LEN)
        else $error("length above capacity");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.full_res |->
            !out_data.applied && !out_data.found && out_data.length_now == CAP_LEN)
        else $error("refused insert with room left");

    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.read_value == '0)
        else $error("read value without hit");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
